### rtl/owr_pkg.sv
// Shared constants and types for the orthogonal wire router.
// Used by owr_route, owr_queue and orthogonal_wire_router; depends on nothing.
package owr_pkg;

  // Default coordinate width: signed fixed point with 4 fractional bits.
  localparam int CoordWidth = 20;

  // Alignment tolerance register.
  localparam int TolWidth = 12;
  localparam logic [TolWidth-1:0] TolReset = 12'd48;

  // Vertex queue: one waypoint yields at most three vertices.
  localparam int QueueDepth = 3;
  localparam int CntWidth   = $clog2(QueueDepth + 1);

  // Configuration port.
  localparam int PaddrWidth = 3;
  localparam int PdataWidth = 32;

  // Word index of each configuration register (paddr bit 2).
  typedef enum logic [0:0] {
    RegAlignTol = 1'b0
  } reg_idx_e;

endpackage

### rtl/owr_route.sv
// Routing decision for one waypoint against the held vertex, plus the held state.
// Depends on owr_pkg for the tolerance width and the vertex queue depth.
module owr_route #(
  parameter int COORD_WIDTH = owr_pkg::CoordWidth
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              fire_i,
  input  logic [COORD_WIDTH-1:0]                            point_x_i,
  input  logic [COORD_WIDTH-1:0]                            point_y_i,
  input  logic                                              final_point_i,
  input  logic [owr_pkg::TolWidth-1:0]                      tol_i,
  output logic [owr_pkg::CntWidth-1:0]                      res_n_o,
  output logic [owr_pkg::QueueDepth-1:0][COORD_WIDTH-1:0]   res_x_o,
  output logic [owr_pkg::QueueDepth-1:0][COORD_WIDTH-1:0]   res_y_o,
  output logic [owr_pkg::QueueDepth-1:0]                    res_fin_o
);

  localparam int DiffWidth = COORD_WIDTH + 1;
  localparam int MagWidth  = (DiffWidth > owr_pkg::TolWidth) ? DiffWidth : owr_pkg::TolWidth;

  logic [COORD_WIDTH-1:0] held_x_q, held_x_d;
  logic [COORD_WIDTH-1:0] held_y_q, held_y_d;
  logic                   have_held_q, have_held_d;
  logic                   held_start_q, held_start_d;

  logic [DiffWidth-1:0] diff_x, diff_y, mag_x, mag_y;
  logic                 align_x, align_y;

  // Differences are taken one bit wider than the coordinates, so they are exact.
  assign diff_x = {held_x_q[COORD_WIDTH-1], held_x_q} - {point_x_i[COORD_WIDTH-1], point_x_i};
  assign diff_y = {held_y_q[COORD_WIDTH-1], held_y_q} - {point_y_i[COORD_WIDTH-1], point_y_i};
  assign mag_x  = diff_x[DiffWidth-1] ? (~diff_x + DiffWidth'(1)) : diff_x;
  assign mag_y  = diff_y[DiffWidth-1] ? (~diff_y + DiffWidth'(1)) : diff_y;
  assign align_x = MagWidth'(mag_x) <= MagWidth'(tol_i);
  assign align_y = MagWidth'(mag_y) <= MagWidth'(tol_i);

  always_comb begin
    res_n_o      = '0;
    res_x_o      = '0;
    res_y_o      = '0;
    res_fin_o    = '0;
    held_x_d     = held_x_q;
    held_y_d     = held_y_q;
    have_held_d  = have_held_q;
    held_start_d = held_start_q;

    if (!have_held_q) begin
      if (final_point_i) begin
        // A one-point wire passes straight through.
        res_n_o      = owr_pkg::CntWidth'(1);
        res_x_o[0]   = point_x_i;
        res_y_o[0]   = point_y_i;
        res_fin_o[0] = 1'b1;
      end else begin
        held_x_d     = point_x_i;
        held_y_d     = point_y_i;
        have_held_d  = 1'b1;
        held_start_d = 1'b1;
      end
    end else begin
      res_x_o[0]   = held_x_q;
      res_y_o[0]   = held_y_q;
      held_start_d = 1'b0;
      if (align_y) begin
        if (final_point_i) begin
          // Snap the held corner onto the pin, unless it is the start point.
          if (!held_start_q) begin
            res_y_o[0] = point_y_i;
          end
          res_n_o      = owr_pkg::CntWidth'(2);
          res_x_o[1]   = point_x_i;
          res_y_o[1]   = point_y_i;
          res_fin_o[1] = 1'b1;
        end else begin
          res_n_o  = owr_pkg::CntWidth'(1);
          held_x_d = point_x_i;
        end
      end else if (align_x) begin
        if (final_point_i) begin
          if (!held_start_q) begin
            res_x_o[0] = point_x_i;
          end
          res_n_o      = owr_pkg::CntWidth'(2);
          res_x_o[1]   = point_x_i;
          res_y_o[1]   = point_y_i;
          res_fin_o[1] = 1'b1;
        end else begin
          res_n_o  = owr_pkg::CntWidth'(1);
          held_y_d = point_y_i;
        end
      end else begin
        // Horizontal-first L: the corner shares the held y and the new x.
        res_x_o[1] = point_x_i;
        res_y_o[1] = held_y_q;
        if (final_point_i) begin
          res_n_o      = owr_pkg::CntWidth'(3);
          res_x_o[2]   = point_x_i;
          res_y_o[2]   = point_y_i;
          res_fin_o[2] = 1'b1;
        end else begin
          res_n_o  = owr_pkg::CntWidth'(2);
          held_x_d = point_x_i;
          held_y_d = point_y_i;
        end
      end
      if (final_point_i) begin
        have_held_d  = 1'b0;
        held_start_d = 1'b0;
        held_x_d     = '0;
        held_y_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_x_q     <= '0;
      held_y_q     <= '0;
      have_held_q  <= 1'b0;
      held_start_q <= 1'b0;
    end else if (fire_i) begin
      held_x_q     <= held_x_d;
      held_y_q     <= held_y_d;
      have_held_q  <= have_held_d;
      held_start_q <= held_start_d;
    end
  end

  // The start flag only makes sense while a wire is in progress.
  a_start_needs_wire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_start_q |-> have_held_q)
    else $error("held vertex marked as start with no wire in progress");

  // A first, non-final waypoint opens a wire and becomes the held start point.
  a_first_point_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !have_held_q && !final_point_i) |=> (have_held_q && held_start_q))
    else $error("first waypoint was not held as the start point");

  // A final waypoint always closes the wire with exactly one final vertex.
  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && final_point_i) |-> ($countones(res_fin_o) == 1 && res_n_o != '0))
    else $error("final waypoint did not produce exactly one final vertex");

endmodule

### rtl/owr_queue.sv
// Vertex queue: takes up to three vertices at a time and sends one beat per cycle unless the receiver stalls.
// Depends on owr_pkg for the queue depth and count width.
module owr_queue #(
  parameter int COORD_WIDTH = owr_pkg::CoordWidth
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic [owr_pkg::CntWidth-1:0]                      push_n_i,
  input  logic [owr_pkg::QueueDepth-1:0][COORD_WIDTH-1:0]   push_x_i,
  input  logic [owr_pkg::QueueDepth-1:0][COORD_WIDTH-1:0]   push_y_i,
  input  logic [owr_pkg::QueueDepth-1:0]                    push_fin_i,
  output logic [owr_pkg::CntWidth-1:0]                      room_o,
  output logic                                              out_valid_o,
  input  logic                                              out_stall_i,
  output logic [COORD_WIDTH-1:0]                            vertex_x_o,
  output logic [COORD_WIDTH-1:0]                            vertex_y_o,
  output logic                                              final_vertex_o
);

  localparam int Depth = owr_pkg::QueueDepth;
  localparam int CntW  = owr_pkg::CntWidth;

  logic [Depth-1:0][COORD_WIDTH-1:0] slot_x_q, slot_x_d, shift_x;
  logic [Depth-1:0][COORD_WIDTH-1:0] slot_y_q, slot_y_d, shift_y;
  logic [Depth-1:0]                  slot_fin_q, slot_fin_d, shift_fin;
  logic [CntW-1:0]                   count_q, count_d, rem;
  logic [CntW-1:0]                   pos;
  logic                              pop;

  assign out_valid_o    = count_q != '0;
  assign pop            = out_valid_o && !out_stall_i;
  assign rem            = count_q - CntW'(pop);
  assign room_o         = CntW'(Depth) - rem;
  assign vertex_x_o     = slot_x_q[0];
  assign vertex_y_o     = slot_y_q[0];
  assign final_vertex_o = slot_fin_q[0];

  always_comb begin
    // Drop the head if it leaves this cycle, then append behind what remains.
    shift_x   = slot_x_q;
    shift_y   = slot_y_q;
    shift_fin = slot_fin_q;
    for (int k = 0; k < Depth - 1; k++) begin
      if (pop) begin
        shift_x[k]   = slot_x_q[k+1];
        shift_y[k]   = slot_y_q[k+1];
        shift_fin[k] = slot_fin_q[k+1];
      end
    end
    slot_x_d   = shift_x;
    slot_y_d   = shift_y;
    slot_fin_d = shift_fin;
    pos        = '0;
    for (int k = 0; k < Depth; k++) begin
      pos = CntW'(k) - rem;
      if (CntW'(k) >= rem && pos < push_n_i) begin
        slot_x_d[k]   = push_x_i[pos];
        slot_y_d[k]   = push_y_i[pos];
        slot_fin_d[k] = push_fin_i[pos];
      end
    end
    count_d = rem + push_n_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_x_q   <= slot_x_d;
    slot_y_q   <= slot_y_d;
    slot_fin_q <= slot_fin_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("vertex queue count exceeds its depth");

  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n_i <= room_o)
    else $error("vertex queue pushed beyond its free room");

  // A held head vertex stays in place while the receiver stalls.
  a_head_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (count_q >= $past(count_q)))
    else $error("vertex queue lost an entry during a stall");

endmodule

### rtl/orthogonal_wire_router.sv
// Top level of the orthogonal wire router: input register, APB register, route, queue.
// Depends on owr_pkg, owr_route and owr_queue.
//
// The router turns a stream of wire waypoints into the vertices of an orthogonal
// polyline. A waypoint beat is registered, measured combinationally against the held
// vertex, and its zero to three vertices go into a three-entry vertex queue that feeds
// the output one beat per cycle while the output does not stall. The input takes a
// beat every cycle as long as the queue has room for the vertices of the registered
// waypoint; the single output channel therefore sets the sustained rate, as a straight
// run yields one vertex, an L corner or a final straight run two, and a final L corner
// three. The first vertex of a waypoint passes through the input register and then
// the queue before it leaves. align_tolerance (byte address 0, reset 48, 1/16 pixel
// units) must only be written while no wire is in flight.
module orthogonal_wire_router #(
  parameter int COORD_WIDTH = owr_pkg::CoordWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [COORD_WIDTH-1:0]         point_x_i,
  input  logic [COORD_WIDTH-1:0]         point_y_i,
  input  logic                           final_point_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [COORD_WIDTH-1:0]         vertex_x_o,
  output logic [COORD_WIDTH-1:0]         vertex_y_o,
  output logic                           final_vertex_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [owr_pkg::PaddrWidth-1:0] paddr,
  input  logic [owr_pkg::PdataWidth-1:0] pwdata,
  output logic [owr_pkg::PdataWidth-1:0] prdata,
  output logic                           pready
);

  localparam int Depth = owr_pkg::QueueDepth;
  localparam int CntW  = owr_pkg::CntWidth;

  logic                             in_valid_q, in_valid_d;
  logic [COORD_WIDTH-1:0]           in_x_q, in_y_q;
  logic                             in_fin_q;
  logic                             in_accept, move;
  logic [owr_pkg::TolWidth-1:0]     tol_q;
  logic                             tol_write;

  logic [CntW-1:0]                  res_n, room, push_n;
  logic [Depth-1:0][COORD_WIDTH-1:0] res_x, res_y;
  logic [Depth-1:0]                 res_fin;

  // Configuration register.
  assign pready    = 1'b1;
  assign tol_write = psel && penable && pwrite && pready &&
                     (paddr[2] == owr_pkg::RegAlignTol);
  assign prdata    = (paddr[2] == owr_pkg::RegAlignTol) ?
                     owr_pkg::PdataWidth'(tol_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= owr_pkg::TolReset;
    end else if (tol_write) begin
      tol_q <= pwdata[owr_pkg::TolWidth-1:0];
    end
  end

  // The registered waypoint moves on once its vertices fit in the queue.
  assign move       = in_valid_q && (res_n <= room);
  assign in_stall_o = in_valid_q && !move;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_valid_d = in_accept || (in_valid_q && !move);
  assign push_n     = move ? res_n : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_x_q   <= point_x_i;
      in_y_q   <= point_y_i;
      in_fin_q <= final_point_i;
    end
  end

  owr_route #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_route (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (move),
    .point_x_i    (in_x_q),
    .point_y_i    (in_y_q),
    .final_point_i(in_fin_q),
    .tol_i        (tol_q),
    .res_n_o      (res_n),
    .res_x_o      (res_x),
    .res_y_o      (res_y),
    .res_fin_o    (res_fin)
  );

  owr_queue #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_n_i      (push_n),
    .push_x_i      (res_x),
    .push_y_i      (res_y),
    .push_fin_i    (res_fin),
    .room_o        (room),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .vertex_x_o    (vertex_x_o),
    .vertex_y_o    (vertex_y_o),
    .final_vertex_o(final_vertex_o)
  );

  // The input side stalls only on a waypoint already waiting in the register.
  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with no waypoint registered");

  // A waypoint that cannot move keeps its register contents.
  a_waiting_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !move) |=> (in_valid_q && $stable(in_x_q) && $stable(in_y_q)))
    else $error("waiting waypoint was overwritten");

  // A stalled vertex beat stays valid and unchanged.
  a_out_beat_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(vertex_x_o) &&
                                      $stable(vertex_y_o) && $stable(final_vertex_o)))
    else $error("stalled vertex beat changed");

endmodule
